FILE: hdl/mlrq_pkg.sv
// ---------------------------------------------------------------------------
// mlrq_pkg
// Shared constants and types for the multilevel ready-queue scheduler.
// ---------------------------------------------------------------------------
package mlrq_pkg;

   localparam int QUEUE_LEVELS = 8;
   localparam int MAX_PROCS    = 64;
   localparam int TICK_BITS    = 16;
   localparam int ID_W         = 6;
   localparam int PRIO_W       = 3;
   localparam int PR_W         = PRIO_W + 2;
   localparam int LVL_W        = $clog2(QUEUE_LEVELS);
   localparam int CNT_W        = $clog2(MAX_PROCS) + 1;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   typedef struct packed {
      logic              op;
      logic [ID_W-1:0]   id;
      logic              slot_ok;
      logic              early;
      logic [PRIO_W-1:0] prio;
      logic [PRIO_W-1:0] floor_lv;
      logic              kernel;
      logic              billable;
      logic [ID_W-1:0]   running;
   } item_type;

endpackage

FILE: hdl/multilevel_ready_queue_scheduler.sv
// ---------------------------------------------------------------------------
// multilevel_ready_queue_scheduler
// Multilevel feedback ready-queue scheduler over linked lists of process slots.
// Every request passes dispatch and finish; a new selection adds pick and
// pick-write. A dequeue may first walk its queue link by link to unlink
// the slot. One request is handled at a time; two queue at the front.
// Reset clears queue occupancy, queued flags and selection state at once.
// ---------------------------------------------------------------------------
module multilevel_ready_queue_scheduler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_op,
   input  logic [mlrq_pkg::ID_W-1:0]      req_proc_id,
   input  logic                           req_proc_present,
   input  logic [mlrq_pkg::TICK_BITS-1:0] req_ticks_used,
   input  logic [mlrq_pkg::TICK_BITS-1:0] req_ticks_quantum,
   input  logic [mlrq_pkg::PRIO_W-1:0]    req_priority_in,
   input  logic [mlrq_pkg::PRIO_W-1:0]    req_priority_floor,
   input  logic                           req_is_kernel,
   input  logic                           req_is_billable,
   input  logic [mlrq_pkg::ID_W-1:0]      req_running_id,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_ok,
   output logic [mlrq_pkg::PRIO_W-1:0]    rsp_new_priority,
   output logic                           rsp_clear_ticks,
   output logic [mlrq_pkg::ID_W-1:0]      rsp_next_id,
   output logic                           rsp_next_valid,
   output logic [mlrq_pkg::ID_W-1:0]      rsp_billable_id,
   output logic                           rsp_billable_valid
);

   logic               item_valid;
   logic               item_pop;
   mlrq_pkg::item_type item;

   mlrq_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_proc_id        (req_proc_id),
      .req_proc_present   (req_proc_present),
      .req_ticks_used     (req_ticks_used),
      .req_ticks_quantum  (req_ticks_quantum),
      .req_priority_in    (req_priority_in),
      .req_priority_floor (req_priority_floor),
      .req_is_kernel      (req_is_kernel),
      .req_is_billable    (req_is_billable),
      .req_running_id     (req_running_id),
      .item_valid         (item_valid),
      .item               (item),
      .item_pop           (item_pop)
   );

   mlrq_back u_back (
      .clock              (clock),
      .reset              (reset),
      .item_valid         (item_valid),
      .item               (item),
      .item_pop           (item_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ok             (rsp_ok),
      .rsp_new_priority   (rsp_new_priority),
      .rsp_clear_ticks    (rsp_clear_ticks),
      .rsp_next_id        (rsp_next_id),
      .rsp_next_valid     (rsp_next_valid),
      .rsp_billable_id    (rsp_billable_id),
      .rsp_billable_valid (rsp_billable_valid)
   );

endmodule

FILE: hdl/mlrq_front.sv
// ---------------------------------------------------------------------------
// mlrq_front
// Accepts request beats, classifies them and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module mlrq_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [mlrq_pkg::ID_W-1:0]     req_proc_id,
   input  logic                          req_proc_present,
   input  logic [mlrq_pkg::TICK_BITS-1:0] req_ticks_used,
   input  logic [mlrq_pkg::TICK_BITS-1:0] req_ticks_quantum,
   input  logic [mlrq_pkg::PRIO_W-1:0]   req_priority_in,
   input  logic [mlrq_pkg::PRIO_W-1:0]   req_priority_floor,
   input  logic                          req_is_kernel,
   input  logic                          req_is_billable,
   input  logic [mlrq_pkg::ID_W-1:0]     req_running_id,
   output logic                          item_valid,
   output mlrq_pkg::item_type            item,
   input  logic                          item_pop
);

   mlrq_pkg::item_type fifo_ff [2];
   mlrq_pkg::item_type new_item;
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push, pop;

   always_comb begin
      new_item.op       = req_op;
      new_item.id       = req_proc_id;
      new_item.slot_ok  = req_proc_present &&
                          ({1'b0, req_proc_id} < (mlrq_pkg::ID_W+1)'(mlrq_pkg::MAX_PROCS));
      new_item.early    = req_ticks_used < req_ticks_quantum;
      new_item.prio     = req_priority_in;
      new_item.floor_lv = req_priority_floor;
      new_item.kernel   = req_is_kernel;
      new_item.billable = req_is_billable;
      new_item.running  = req_running_id;
   end

   assign req_stall  = count_ff == 2'd2;
   assign push       = req_valid && !req_stall;
   assign item_valid = count_ff != 2'd0;
   assign pop        = item_pop && item_valid;
   assign item       = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

FILE: hdl/mlrq_back.sv
// ---------------------------------------------------------------------------
// mlrq_back
// Applies the feedback rule, links and unlinks slots, selects the next slot.
// ---------------------------------------------------------------------------
module mlrq_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_valid,
   input  mlrq_pkg::item_type          item,
   output logic                        item_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_ok,
   output logic [mlrq_pkg::PRIO_W-1:0] rsp_new_priority,
   output logic                        rsp_clear_ticks,
   output logic [mlrq_pkg::ID_W-1:0]   rsp_next_id,
   output logic                        rsp_next_valid,
   output logic [mlrq_pkg::ID_W-1:0]   rsp_billable_id,
   output logic                        rsp_billable_valid
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_DISPATCH = 7'b0000010,
      S_WALK_RD  = 7'b0000100,
      S_WALK_CHK = 7'b0001000,
      S_PICK     = 7'b0010000,
      S_PICK_WR  = 7'b0100000,
      S_FINISH   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   mlrq_pkg::item_type item_ff, item_in;

   logic [mlrq_pkg::ID_W-1:0]  head_ff [mlrq_pkg::QUEUE_LEVELS];
   logic [mlrq_pkg::ID_W-1:0]  tail_ff [mlrq_pkg::QUEUE_LEVELS];
   logic [mlrq_pkg::QUEUE_LEVELS-1:0] nonempty_ff;
   logic [mlrq_pkg::MAX_PROCS-1:0]    queued_ff;

   logic [mlrq_pkg::ID_W-1:0]  link_mem [mlrq_pkg::MAX_PROCS];
   logic [mlrq_pkg::LVL_W-1:0] prio_mem [mlrq_pkg::MAX_PROCS];
   logic                       bill_mem [mlrq_pkg::MAX_PROCS];
   logic [mlrq_pkg::ID_W-1:0]  link_rd_ff;
   logic [mlrq_pkg::LVL_W-1:0] prio_rd_ff;
   logic                       bill_rd_ff;

   logic [mlrq_pkg::ID_W-1:0]  cur_ff, cur_in, lp_ff, lp_in, cand_ff, cand_in;
   logic [mlrq_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [mlrq_pkg::LVL_W-1:0] q_ff, q_in;
   logic                       repick_ff, repick_in;
   logic                       res_ok_ff, res_ok_in, res_clr_ff, res_clr_in;
   logic [mlrq_pkg::PRIO_W-1:0] res_prio_ff, res_prio_in;
   logic [mlrq_pkg::ID_W-1:0]  le_id_ff, le_id_in, chosen_id_ff, chosen_id_in;
   logic [mlrq_pkg::ID_W-1:0]  billed_id_ff, billed_id_in;
   logic                       le_valid_ff, le_valid_in, chosen_valid_ff, chosen_valid_in;
   logic                       billed_valid_ff, billed_valid_in;

   logic                       rsp_valid_ff, rsp_valid_in, rsp_ok_ff, rsp_clr_ff;
   logic [mlrq_pkg::PRIO_W-1:0] rsp_prio_ff;
   logic [mlrq_pkg::ID_W-1:0]  rsp_next_id_ff, rsp_bill_id_ff;
   logic                       rsp_next_valid_ff, rsp_bill_valid_ff, rsp_load;

   logic [mlrq_pkg::LVL_W-1:0] hq_addr, q_enq, best;
   logic [mlrq_pkg::ID_W-1:0]  head_rd, tail_rd;
   logic                       any_ne;
   logic signed [mlrq_pkg::PR_W-1:0] sum;
   logic [mlrq_pkg::PRIO_W-1:0] pr;
   logic                       pr_ok;

   logic                       head_we, tail_we, ne_set, ne_clr, queued_set, queued_clr;
   logic [mlrq_pkg::ID_W-1:0]  head_wd, tail_wd;
   logic                       link_we, slot_we;
   logic [mlrq_pkg::ID_W-1:0]  link_wa, link_wd, link_ra;

   always_comb begin
      best = '0;
      for (int i = mlrq_pkg::QUEUE_LEVELS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            best = mlrq_pkg::LVL_W'(i);
         end
      end
   end
   assign any_ne = |nonempty_ff;

   always_comb begin
      sum = signed'(mlrq_pkg::PR_W'(item_ff.prio)) +
            ((le_valid_ff && le_id_ff == item_ff.id) ? mlrq_pkg::PR_W'(1) :
                                                      -mlrq_pkg::PR_W'(1));
      if (sum < signed'(mlrq_pkg::PR_W'(item_ff.floor_lv))) begin
         sum = signed'(mlrq_pkg::PR_W'(item_ff.floor_lv));
      end
      if (sum >= signed'(mlrq_pkg::PR_W'(mlrq_pkg::QUEUE_LEVELS))) begin
         sum = signed'(mlrq_pkg::PR_W'(mlrq_pkg::QUEUE_LEVELS - 1));
      end
      if (item_ff.early && !item_ff.kernel) begin
         pr = sum[mlrq_pkg::PRIO_W-1:0];
      end else begin
         pr = item_ff.prio;
      end
      pr_ok = {1'b0, pr} < (mlrq_pkg::PRIO_W+1)'(mlrq_pkg::QUEUE_LEVELS);
      q_enq = pr[mlrq_pkg::LVL_W-1:0];
   end

   always_comb begin
      case (state_ff)
         S_DISPATCH: hq_addr = (item_ff.op == mlrq_pkg::OP_DEQUEUE) ? prio_rd_ff : q_enq;
         S_PICK:     hq_addr = best;
         default:    hq_addr = q_ff;
      endcase
   end
   assign head_rd  = head_ff[hq_addr];
   assign tail_rd  = tail_ff[hq_addr];
   assign rsp_load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in        = state_ff;
      item_in         = item_ff;
      cur_in          = cur_ff;
      lp_in           = lp_ff;
      cand_in         = cand_ff;
      cnt_in          = cnt_ff;
      q_in            = q_ff;
      repick_in       = repick_ff;
      res_ok_in       = res_ok_ff;
      res_clr_in      = res_clr_ff;
      res_prio_in     = res_prio_ff;
      le_id_in        = le_id_ff;
      le_valid_in     = le_valid_ff;
      chosen_id_in    = chosen_id_ff;
      chosen_valid_in = chosen_valid_ff;
      billed_id_in    = billed_id_ff;
      billed_valid_in = billed_valid_ff;
      item_pop        = 1'b0;
      head_we         = 1'b0;
      head_wd         = item_ff.id;
      tail_we         = 1'b0;
      tail_wd         = item_ff.id;
      ne_set          = 1'b0;
      ne_clr          = 1'b0;
      queued_set      = 1'b0;
      queued_clr      = 1'b0;
      link_we         = 1'b0;
      link_wa         = item_ff.id;
      link_wd         = item_ff.id;
      slot_we         = 1'b0;
      link_ra         = cur_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            link_ra = item.id;
            if (item_valid) begin
               item_pop = 1'b1;
               item_in  = item;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_ok_in   = 1'b0;
            res_clr_in  = 1'b0;
            res_prio_in = item_ff.prio;
            state_in    = S_FINISH;
            if (item_ff.slot_ok) begin
               if (item_ff.op == mlrq_pkg::OP_ENQUEUE) begin
                  if (!queued_ff[item_ff.id]) begin
                     res_clr_in  = item_ff.early;
                     res_prio_in = pr;
                     res_ok_in   = pr_ok;
                     if (item_ff.early) begin
                        le_id_in    = item_ff.id;
                        le_valid_in = 1'b1;
                     end
                     if (pr_ok) begin
                        queued_set = 1'b1;
                        slot_we    = 1'b1;
                        state_in   = S_PICK;
                        if (!nonempty_ff[q_enq]) begin
                           head_we = 1'b1;
                           tail_we = 1'b1;
                           ne_set  = 1'b1;
                        end else if (!item_ff.early) begin
                           link_we = 1'b1;
                           link_wd = head_rd;
                           head_we = 1'b1;
                        end else begin
                           link_we = 1'b1;
                           link_wa = tail_rd;
                           tail_we = 1'b1;
                        end
                     end
                  end
               end else if (queued_ff[item_ff.id]) begin
                  res_ok_in   = 1'b1;
                  res_prio_in = mlrq_pkg::PRIO_W'(prio_rd_ff);
                  queued_clr  = 1'b1;
                  repick_in   = (item_ff.id == item_ff.running) ||
                                (chosen_valid_ff && chosen_id_ff == item_ff.id);
                  q_in        = prio_rd_ff;
                  if (head_rd == item_ff.id) begin
                     if (tail_rd == item_ff.id) begin
                        ne_clr = 1'b1;
                     end else begin
                        head_we = 1'b1;
                        head_wd = link_rd_ff;
                     end
                     state_in = repick_in ? S_PICK : S_FINISH;
                  end else begin
                     cur_in   = head_rd;
                     cnt_in   = '0;
                     lp_in    = link_rd_ff;
                     state_in = S_WALK_RD;
                  end
               end else begin
                  res_ok_in = {1'b0, item_ff.prio} <
                              (mlrq_pkg::PRIO_W+1)'(mlrq_pkg::QUEUE_LEVELS);
               end
            end
         end
         S_WALK_RD: begin
            if (cur_ff != tail_rd && cnt_ff < mlrq_pkg::CNT_W'(mlrq_pkg::MAX_PROCS)) begin
               state_in = S_WALK_CHK;
            end else begin
               state_in = repick_ff ? S_PICK : S_FINISH;
            end
         end
         S_WALK_CHK: begin
            if (link_rd_ff == item_ff.id) begin
               link_we = 1'b1;
               link_wa = cur_ff;
               link_wd = lp_ff;
               if (tail_rd == item_ff.id) begin
                  tail_we = 1'b1;
                  tail_wd = cur_ff;
               end
               state_in = repick_ff ? S_PICK : S_FINISH;
            end else begin
               cur_in   = link_rd_ff;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_WALK_RD;
            end
         end
         S_PICK: begin
            if (any_ne) begin
               cand_in  = head_rd;
               state_in = S_PICK_WR;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_PICK_WR: begin
            chosen_id_in    = cand_ff;
            chosen_valid_in = 1'b1;
            if (bill_rd_ff) begin
               billed_id_in    = cand_ff;
               billed_valid_in = 1'b1;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         nonempty_ff     <= '0;
         queued_ff       <= '0;
         le_id_ff        <= '0;
         le_valid_ff     <= 1'b0;
         chosen_id_ff    <= '0;
         chosen_valid_ff <= 1'b0;
         billed_id_ff    <= '0;
         billed_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         le_id_ff        <= le_id_in;
         le_valid_ff     <= le_valid_in;
         chosen_id_ff    <= chosen_id_in;
         chosen_valid_ff <= chosen_valid_in;
         billed_id_ff    <= billed_id_in;
         billed_valid_ff <= billed_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (ne_set) begin
            nonempty_ff[hq_addr] <= 1'b1;
         end
         if (ne_clr) begin
            nonempty_ff[hq_addr] <= 1'b0;
         end
         if (queued_set) begin
            queued_ff[item_ff.id] <= 1'b1;
         end
         if (queued_clr) begin
            queued_ff[item_ff.id] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      cur_ff      <= cur_in;
      lp_ff       <= lp_in;
      cand_ff     <= cand_in;
      cnt_ff      <= cnt_in;
      q_ff        <= q_in;
      repick_ff   <= repick_in;
      res_ok_ff   <= res_ok_in;
      res_clr_ff  <= res_clr_in;
      res_prio_ff <= res_prio_in;
      if (head_we) begin
         head_ff[hq_addr] <= head_wd;
      end
      if (tail_we) begin
         tail_ff[hq_addr] <= tail_wd;
      end
      if (state_ff == S_FINISH && rsp_load) begin
         rsp_ok_ff         <= res_ok_ff;
         rsp_prio_ff       <= res_prio_ff;
         rsp_clr_ff        <= res_clr_ff;
         rsp_next_id_ff    <= chosen_id_ff;
         rsp_next_valid_ff <= chosen_valid_ff;
         rsp_bill_id_ff    <= billed_id_ff;
         rsp_bill_valid_ff <= billed_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_rd_ff <= link_mem[link_ra];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         prio_mem[item_ff.id] <= q_enq;
         bill_mem[item_ff.id] <= item_ff.billable;
      end
      prio_rd_ff <= prio_mem[item.id];
      bill_rd_ff <= bill_mem[head_rd];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_new_priority   = rsp_prio_ff;
   assign rsp_clear_ticks    = rsp_clr_ff;
   assign rsp_next_id        = rsp_next_id_ff;
   assign rsp_next_valid     = rsp_next_valid_ff;
   assign rsp_billable_id    = rsp_bill_id_ff;
   assign rsp_billable_valid = rsp_bill_valid_ff;

`ifndef SYNTHESIS
   a_enq_linked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PICK && item_ff.op == mlrq_pkg::OP_ENQUEUE) |-> queued_ff[item_ff.id])
      else $error("enqueued slot not marked queued before selection");
   a_walk_unqueued: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK_RD || state_ff == S_WALK_CHK) |-> !queued_ff[item_ff.id])
      else $error("slot still queued while being unlinked");
   a_ne_dispatch_only: assert property (@(posedge clock) disable iff (reset)
      (!reset && state_ff != S_DISPATCH) |=> $stable(nonempty_ff))
      else $error("queue occupancy changed outside dispatch");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> (state_ff == S_IDLE && item_valid))
      else $error("item taken outside idle");
`endif

endmodule
